>>> rtl/cbk_pkg.sv
// Shared types and constants for the per-entry circuit breaker.
// No dependencies; imported by cbk_update and per_entry_circuit_breaker.
package cbk_pkg;

   typedef enum logic [1:0] {
      CMD_ALLOW   = 2'd0,
      CMD_SUCCESS = 2'd1,
      CMD_FAILURE = 2'd2,
      CMD_RELEASE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_CLOSED = 2'd0,
      MODE_OPEN   = 2'd1,
      MODE_HALF   = 2'd2
   } breaker_mode_type;

   // Control part of one table entry; the deadline travels beside it.
   typedef struct packed {
      logic             probe;
      logic [7:0]       tally;
      breaker_mode_type mode;
   } entry_flags_type;

   localparam int FLAG_W = $bits(entry_flags_type);

   localparam logic CSR_FAIL_THRESHOLD   = 1'b0;
   localparam logic CSR_COOLDOWN_SECONDS = 1'b1;

   localparam logic [5:0]  THRESH_MIN     = 6'd1;
   localparam logic [5:0]  THRESH_MAX     = 6'd50;
   localparam logic [5:0]  THRESH_RST     = 6'd3;
   localparam logic [7:0]  TALLY_MAX      = 8'd255;
   localparam int          COOLDOWN_US_W  = 36;
   localparam logic [19:0] USEC_PER_SEC   = 20'd1000000;
   localparam logic [35:0] COOLDOWN_US_RST = 36'd60000000;

   // Stored deadline width: wide enough that an unsaturated deadline never wraps.
   function automatic int cbk_dl_width(input int time_bits);
      return (time_bits > COOLDOWN_US_W + 1) ? time_bits : COOLDOWN_US_W + 1;
   endfunction

endpackage

>>> rtl/cbk_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the breaker table.
module cbk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic                                  re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/cbk_update.sv
// Next-state logic for one breaker entry: command decode, failure count,
// cooldown deadline arming. Depends on cbk_pkg.
module cbk_update import cbk_pkg::*; #(
   parameter int TIME_BITS = 48
) (
   input  cmd_type                                 cmd,
   input  logic [cbk_dl_width(TIME_BITS)-1:0]      now,
   input  entry_flags_type                         flags_cur,
   input  logic [cbk_dl_width(TIME_BITS)-1:0]      deadline_cur,
   input  logic [5:0]                              threshold,
   input  logic [COOLDOWN_US_W-1:0]                cooldown_us,
   output entry_flags_type                         flags_nxt,
   output logic [cbk_dl_width(TIME_BITS)-1:0]      deadline_nxt,
   output logic                                    allowed
);

   localparam int DL_W  = cbk_dl_width(TIME_BITS);
   localparam int SUM_W = ((TIME_BITS > COOLDOWN_US_W) ? TIME_BITS : COOLDOWN_US_W) + 1;
   localparam logic [64:0] MASK65 = (65'd1 << TIME_BITS) - 65'd1;
   localparam logic [SUM_W-1:0] TIME_MASK = MASK65[SUM_W-1:0];

   logic [SUM_W-1:0] now_ext;
   logic [SUM_W-1:0] add_ext;
   logic [SUM_W-1:0] sum;
   logic             saturate;
   logic [DL_W-1:0]  open_deadline;
   logic [7:0]       tally_inc;

   // Deadline clips to the top of the time range, unless the cooldown alone exceeds it
   assign now_ext       = SUM_W'(now);
   assign add_ext       = SUM_W'(cooldown_us);
   assign sum           = now_ext + add_ext;
   assign saturate      = (add_ext <= TIME_MASK) && (sum > TIME_MASK);
   assign open_deadline = saturate ? MASK65[DL_W-1:0] : sum[DL_W-1:0];
   assign tally_inc     = (flags_cur.tally == TALLY_MAX) ? TALLY_MAX : flags_cur.tally + 8'd1;

   always_comb begin
      logic do_open;
      do_open      = 1'b0;
      flags_nxt    = flags_cur;
      deadline_nxt = deadline_cur;
      allowed      = 1'b0;
      case (cmd)
         CMD_ALLOW: begin
            case (flags_cur.mode)
               MODE_OPEN: begin
                  if (now >= deadline_cur) begin
                     flags_nxt.mode  = MODE_HALF;
                     flags_nxt.probe = 1'b1;
                     allowed         = 1'b1;
                  end
               end
               MODE_HALF: begin
                  if (!flags_cur.probe) begin
                     flags_nxt.probe = 1'b1;
                     allowed         = 1'b1;
                  end
               end
               default: begin
                  allowed = 1'b1;
               end
            endcase
         end
         CMD_SUCCESS: begin
            flags_nxt.mode  = MODE_CLOSED;
            flags_nxt.tally = 8'd0;
            flags_nxt.probe = 1'b0;
            deadline_nxt    = '0;
         end
         CMD_FAILURE: begin
            case (flags_cur.mode)
               MODE_HALF: begin
                  flags_nxt.tally = tally_inc;
                  do_open         = 1'b1;
               end
               MODE_CLOSED: begin
                  flags_nxt.tally = tally_inc;
                  do_open         = (tally_inc >= 8'(threshold));
               end
               default: begin
               end
            endcase
         end
         CMD_RELEASE: begin
            do_open = (flags_cur.mode == MODE_HALF) && flags_cur.probe;
         end
         default: begin
         end
      endcase
      if (do_open) begin
         flags_nxt.mode  = MODE_OPEN;
         flags_nxt.probe = 1'b0;
         deadline_nxt    = open_deadline;
      end
   end

endmodule

>>> rtl/per_entry_circuit_breaker.sv
// Top level of the per-entry circuit breaker: input stage, table RAM,
// write-back forwarding and result register. Depends on cbk_pkg, cbk_ram, cbk_update.
//
//   channel  prefix  direction  handshake   carries
//   request  req_    in         valid/ready cmd, entry_index, now_us
//   response rsp_    out        valid/ready allowed, breaker_now, failures_now
//   config   csr_    in         write only  fail_threshold, cooldown_seconds
//
// One item per cycle sustained while responses are taken; an accepted item passes the
// input stage and then the result register before its result handshake
// (table read into the input stage, then update and write-back into rsp).
// After reset a clearing pass writes every entry, with req_ready low;
// config writes are taken throughout.
// A stalled response holds the input stage; outside clearing, req_ready drops only when both are full.
module per_entry_circuit_breaker import cbk_pkg::*; #(
   parameter int NUM_ENTRIES = 64,
   parameter int TIME_BITS   = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [5:0]  req_entry_index,
   input  logic [47:0] req_now_us,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_allowed,
   output logic [1:0]  rsp_breaker_now,
   output logic [7:0]  rsp_failures_now,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int ADDR_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(NUM_ENTRIES + 1);
   localparam int CMP_W  = (CNT_W > 6) ? CNT_W : 6;
   localparam int DL_W   = cbk_dl_width(TIME_BITS);
   localparam int WORD_W = FLAG_W + DL_W;
   localparam logic [CMP_W-1:0]  ENTRIES_C = CMP_W'(NUM_ENTRIES);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_ENTRIES - 1);

   // configuration
   logic [5:0]               thr_ff, thr_in;
   logic [COOLDOWN_US_W-1:0] cooldown_us_ff, cooldown_us_in;

   // clearing pass
   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   // input stage
   logic              s1_valid_ff, s1_valid_in;
   cmd_type           s1_cmd_ff, s1_cmd_in;
   logic              s1_ok_ff, s1_ok_in;
   logic [ADDR_W-1:0] s1_addr_ff, s1_addr_in;
   logic [DL_W-1:0]   s1_now_ff, s1_now_in;

   // last write into the table
   logic              fwd_valid_ff, fwd_valid_in;
   logic [ADDR_W-1:0] fwd_addr_ff, fwd_addr_in;
   logic [WORD_W-1:0] fwd_data_ff, fwd_data_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_allowed_ff, rsp_allowed_in;
   logic [1:0] rsp_mode_ff, rsp_mode_in;
   logic [7:0] rsp_tally_ff, rsp_tally_in;

   logic              accept;
   logic              s1_advance;
   logic              s1_fire;
   logic [CMP_W-1:0]  req_idx_ext;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [WORD_W-1:0] ram_wdata;
   logic [WORD_W-1:0] ram_rdata;
   logic [WORD_W-1:0] cur_word;
   entry_flags_type   flags_cur, flags_nxt;
   logic [DL_W-1:0]   deadline_cur, deadline_nxt;
   logic              upd_allowed;
   logic [5:0]        thr_raw;

   assign s1_advance  = !rsp_valid_ff || rsp_ready;
   assign s1_fire     = s1_valid_ff && s1_advance;
   assign req_ready   = !clearing_ff && (!s1_valid_ff || s1_advance);
   assign accept      = req_valid && req_ready;
   assign req_idx_ext = CMP_W'(req_entry_index);

   // Entry read at acceptance; the previous write-back is not yet visible in the RAM
   assign cur_word = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : ram_rdata;
   assign flags_cur    = entry_flags_type'(cur_word[WORD_W-1:DL_W]);
   assign deadline_cur = cur_word[DL_W-1:0];

   assign ram_we    = clearing_ff || (s1_fire && s1_ok_ff);
   assign ram_waddr = clearing_ff ? clr_addr_ff : s1_addr_ff;
   assign ram_wdata = clearing_ff ? '0 : {flags_nxt, deadline_nxt};

   cbk_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_ENTRIES)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (accept),
      .raddr (req_idx_ext[ADDR_W-1:0]),
      .rdata (ram_rdata)
   );

   cbk_update #(
      .TIME_BITS (TIME_BITS)
   ) u_update (
      .cmd          (s1_cmd_ff),
      .now          (s1_now_ff),
      .flags_cur    (flags_cur),
      .deadline_cur (deadline_cur),
      .threshold    (thr_ff),
      .cooldown_us  (cooldown_us_ff),
      .flags_nxt    (flags_nxt),
      .deadline_nxt (deadline_nxt),
      .allowed      (upd_allowed)
   );

   assign thr_raw = csr_wdata[5:0];

   always_comb begin
      thr_in         = thr_ff;
      cooldown_us_in = cooldown_us_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FAIL_THRESHOLD: begin
               if (thr_raw < THRESH_MIN) begin
                  thr_in = THRESH_MIN;
               end else if (thr_raw > THRESH_MAX) begin
                  thr_in = THRESH_MAX;
               end else begin
                  thr_in = thr_raw;
               end
            end
            CSR_COOLDOWN_SECONDS: begin
               cooldown_us_in = COOLDOWN_US_W'(csr_wdata) * COOLDOWN_US_W'(USEC_PER_SEC);
            end
            default: begin
            end
         endcase
      end

      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            clearing_in = 1'b0;
         end
      end

      s1_valid_in = s1_valid_ff;
      s1_cmd_in   = s1_cmd_ff;
      s1_ok_in    = s1_ok_ff;
      s1_addr_in  = s1_addr_ff;
      s1_now_in   = s1_now_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_cmd_in   = cmd_type'(req_cmd);
         s1_ok_in    = (req_idx_ext < ENTRIES_C);
         s1_addr_in  = req_idx_ext[ADDR_W-1:0];
         s1_now_in   = DL_W'(TIME_BITS'(req_now_us));
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end

      fwd_valid_in = fwd_valid_ff;
      fwd_addr_in  = fwd_addr_ff;
      fwd_data_in  = fwd_data_ff;
      if (ram_we) begin
         fwd_valid_in = 1'b1;
         fwd_addr_in  = ram_waddr;
         fwd_data_in  = ram_wdata;
      end

      rsp_valid_in   = rsp_valid_ff;
      rsp_allowed_in = rsp_allowed_ff;
      rsp_mode_in    = rsp_mode_ff;
      rsp_tally_in   = rsp_tally_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
         if (s1_ok_ff) begin
            rsp_allowed_in = upd_allowed;
            rsp_mode_in    = flags_nxt.mode;
            rsp_tally_in   = flags_nxt.tally;
         end else begin
            // index beyond the table: no state, queries pass
            rsp_allowed_in = (s1_cmd_ff == CMD_ALLOW);
            rsp_mode_in    = MODE_CLOSED;
            rsp_tally_in   = 8'd0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff         <= THRESH_RST;
         cooldown_us_ff <= COOLDOWN_US_RST;
         clearing_ff    <= 1'b1;
         clr_addr_ff    <= '0;
         s1_valid_ff    <= 1'b0;
         fwd_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         thr_ff         <= thr_in;
         cooldown_us_ff <= cooldown_us_in;
         clearing_ff    <= clearing_in;
         clr_addr_ff    <= clr_addr_in;
         s1_valid_ff    <= s1_valid_in;
         fwd_valid_ff   <= fwd_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      s1_cmd_ff      <= s1_cmd_in;
      s1_ok_ff       <= s1_ok_in;
      s1_addr_ff     <= s1_addr_in;
      s1_now_ff      <= s1_now_in;
      fwd_addr_ff    <= fwd_addr_in;
      fwd_data_ff    <= fwd_data_in;
      rsp_allowed_ff <= rsp_allowed_in;
      rsp_mode_ff    <= rsp_mode_in;
      rsp_tally_ff   <= rsp_tally_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_allowed      = rsp_allowed_ff;
   assign rsp_breaker_now  = rsp_mode_ff;
   assign rsp_failures_now = rsp_tally_ff;

   // No item may sit in the input stage while the table is being cleared
   a_no_item_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !s1_valid_ff)
      else $error("item in input stage during clearing pass");

   // A finished update always lands in the result register
   a_fire_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid_ff)
      else $error("update fired without a result");

   // Only an allow query can grant
   a_allow_only_query: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_cmd_ff != CMD_ALLOW) |=> !rsp_allowed_ff)
      else $error("grant on a non-query command");

   // A breaker can only have left closed through at least one failure
   a_open_has_failures: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_mode_ff != MODE_CLOSED) |-> (rsp_tally_ff != 8'd0))
      else $error("breaker not closed with zero failures");

   a_mode_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_mode_ff == MODE_CLOSED || rsp_mode_ff == MODE_OPEN ||
                        rsp_mode_ff == MODE_HALF))
      else $error("illegal breaker state reported");

endmodule

>>> test/per_entry_circuit_breaker_tb.sv
// Self-checking testbench for per_entry_circuit_breaker: directed and random command
// sequences under several register settings, scored against an in-bench breaker table.
// Depends on rtl/cbk_pkg.sv and the per_entry_circuit_breaker RTL.
`timescale 1ns / 1ps

module per_entry_circuit_breaker_tb;
   import cbk_pkg::*;

   localparam int          ENTRIES  = 64;
   localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

   typedef struct {
      cmd_type     cmd;
      logic [5:0]  entry;
      logic [47:0] now;
   } breaker_cmd_type;

   typedef struct {
      logic             allowed;
      breaker_mode_type mode;
      logic [7:0]       tally;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = CMD_ALLOW;
   logic [5:0]  req_entry_index = '0;
   logic [47:0] req_now_us = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_allowed;
   logic [1:0]  rsp_breaker_now;
   logic [7:0]  rsp_failures_now;
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_FAIL_THRESHOLD;
   logic [15:0] csr_wdata = '0;

   per_entry_circuit_breaker DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_entry_index  (req_entry_index),
      .req_now_us       (req_now_us),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_allowed      (rsp_allowed),
      .rsp_breaker_now  (rsp_breaker_now),
      .rsp_failures_now (rsp_failures_now),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // breaker table shadow and register copies
   breaker_mode_type mode_tab [ENTRIES];
   logic [7:0]       tally_tab [ENTRIES];
   logic [47:0]      deadline_tab [ENTRIES];
   bit               probe_tab [ENTRIES];
   logic [5:0]       thr_cfg;
   logic [15:0]      cool_cfg;

   breaker_cmd_type pending_cmds [$];
   verdict_type     predicted_verdicts [$];

   bit          req_fired = 1'b0;
   int          mismatches = 0;
   int          results_seen = 0;
   int          grants_seen = 0;
   int          saturated_seen = 0;
   logic [47:0] sim_us = 48'd0;

   function automatic void trip_entry(int e, logic [47:0] now);
      logic [63:0] add;
      add = 64'(cool_cfg) * 64'd1000000;
      mode_tab[e] = MODE_OPEN;
      probe_tab[e] = 1'b0;
      if ({16'h0, now} > {16'h0, TIME_MAX} - add)
         deadline_tab[e] = TIME_MAX;
      else
         deadline_tab[e] = now + add[47:0];
   endfunction

   function automatic verdict_type step_breaker(cmd_type cmd, logic [5:0] entry,
                                                logic [47:0] now);
      verdict_type v;
      int e;
      e = int'(entry);
      v.allowed = 1'b0;
      case (cmd)
         CMD_ALLOW: begin
            if (mode_tab[e] == MODE_OPEN) begin
               if (now >= deadline_tab[e]) begin
                  mode_tab[e] = MODE_HALF;
                  probe_tab[e] = 1'b1;
                  v.allowed = 1'b1;
               end
            end else if (mode_tab[e] == MODE_HALF) begin
               if (!probe_tab[e]) begin
                  probe_tab[e] = 1'b1;
                  v.allowed = 1'b1;
               end
            end else begin
               v.allowed = 1'b1;
            end
         end
         CMD_SUCCESS: begin
            mode_tab[e] = MODE_CLOSED;
            tally_tab[e] = 8'd0;
            probe_tab[e] = 1'b0;
            deadline_tab[e] = 48'd0;
         end
         CMD_FAILURE: begin
            if (mode_tab[e] == MODE_HALF) begin
               if (tally_tab[e] != TALLY_MAX) tally_tab[e] = tally_tab[e] + 8'd1;
               trip_entry(e, now);
            end else if (mode_tab[e] == MODE_CLOSED) begin
               if (tally_tab[e] != TALLY_MAX) tally_tab[e] = tally_tab[e] + 8'd1;
               if (tally_tab[e] >= {2'b00, thr_cfg}) trip_entry(e, now);
            end
         end
         default: begin
            if (mode_tab[e] == MODE_HALF && probe_tab[e]) trip_entry(e, now);
         end
      endcase
      v.mode = mode_tab[e];
      v.tally = tally_tab[e];
      return v;
   endfunction

   // Predict on acceptance, score on delivery
   always @(posedge clock) begin
      verdict_type want;
      req_fired = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predicted_verdicts.push_back(step_breaker(cmd_type'(req_cmd), req_entry_index,
                                                      req_now_us));
            req_fired = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_verdicts.size() == 0) begin
               if (mismatches < 10)
                  $display("%t: result with nothing outstanding: allowed=%0b mode=%0d tally=%0d",
                           $realtime, rsp_allowed, rsp_breaker_now, rsp_failures_now);
               mismatches++;
            end else begin
               want = predicted_verdicts.pop_front();
               results_seen++;
               if (want.allowed) grants_seen++;
               if (want.tally == TALLY_MAX) saturated_seen++;
               if (rsp_allowed !== want.allowed || rsp_breaker_now !== want.mode ||
                   rsp_failures_now !== want.tally) begin
                  if (mismatches < 10)
                     $display("%t: result %0d: allowed %0b/%0b mode %0d/%0d tally %0d/%0d (exp/act)",
                              $realtime, results_seen, want.allowed, rsp_allowed, want.mode,
                              rsp_breaker_now, want.tally, rsp_failures_now);
                  mismatches++;
               end
            end
         end
      end
   end

   // Sender: bursts of random length, random gaps in between
   int burst_left = 0;
   int gap_left = 0;

   always @(negedge clock) begin
      breaker_cmd_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            it = pending_cmds.pop_front();
            req_cmd <= it.cmd;
            req_entry_index <= it.entry;
            req_now_us <= it.now;
            req_valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stall pattern switches among four modes picked at random
   int stall_mode = 0;
   int stall_cycle = 0;
   int stall_hold = 0;

   always @(negedge clock) begin
      logic rdy;
      stall_cycle++;
      if (stall_cycle % 300 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rdy = 1'b1;
         1: rdy = (stall_cycle % 4 != 0);
         2: rdy = 1'($urandom_range(0, 1));
         default: begin
            if (stall_hold > 0) begin
               stall_hold--;
               rdy = 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
               stall_hold = $urandom_range(1, 8);
               rdy = 1'b0;
            end else begin
               rdy = 1'b1;
            end
         end
      endcase
      rsp_ready <= rdy;
   end

   function automatic void queue_cmd(cmd_type cmd, logic [5:0] entry, logic [47:0] now);
      breaker_cmd_type it;
      it.cmd = cmd;
      it.entry = entry;
      it.now = now;
      pending_cmds.push_back(it);
   endfunction

   function automatic logic [47:0] rand_time();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[47:0];
   endfunction

   task automatic write_csr(logic idx, logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_FAIL_THRESHOLD) begin
         thr_cfg = val[5:0];
         if (thr_cfg < THRESH_MIN) thr_cfg = THRESH_MIN;
         if (thr_cfg > THRESH_MAX) thr_cfg = THRESH_MAX;
      end else begin
         cool_cfg = val;
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Block is idle once every queued item is through and every result is back
   task automatic drain();
      while (pending_cmds.size() != 0 || req_valid || predicted_verdicts.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic directed_cmds();
      // trip, early refusal, probe grant, probe refusal, release, failure while open
      queue_cmd(CMD_FAILURE, 6'd0, 48'd1000);
      queue_cmd(CMD_FAILURE, 6'd0, 48'd2000);
      queue_cmd(CMD_FAILURE, 6'd0, 48'd3000);
      queue_cmd(CMD_ALLOW,   6'd0, 48'd60_002_999);
      queue_cmd(CMD_ALLOW,   6'd0, 48'd60_003_000);
      queue_cmd(CMD_ALLOW,   6'd0, 48'd60_003_001);
      queue_cmd(CMD_RELEASE, 6'd0, 48'd60_003_100);
      queue_cmd(CMD_FAILURE, 6'd0, 48'd60_003_200);
      queue_cmd(CMD_ALLOW,   6'd0, 48'd120_003_100);
      queue_cmd(CMD_FAILURE, 6'd0, 48'd120_003_200);
      queue_cmd(CMD_ALLOW,   6'd0, 48'd180_003_200);
      queue_cmd(CMD_SUCCESS, 6'd0, 48'd180_003_300);
      // deadline saturates at the top of the time range
      queue_cmd(CMD_FAILURE, 6'd63, TIME_MAX);
      queue_cmd(CMD_FAILURE, 6'd63, TIME_MAX);
      queue_cmd(CMD_FAILURE, 6'd63, TIME_MAX);
      queue_cmd(CMD_ALLOW,   6'd63, TIME_MAX);
      // release with no probe, success and allow on a closed entry
      queue_cmd(CMD_RELEASE, 6'd42, 48'd0);
      queue_cmd(CMD_SUCCESS, 6'd42, 48'd0);
      queue_cmd(CMD_ALLOW,   6'd42, 48'd0);
      // deadline lands exactly on the top of the range
      queue_cmd(CMD_FAILURE, 6'd21, TIME_MAX - 48'd60_000_000);
      queue_cmd(CMD_FAILURE, 6'd21, TIME_MAX - 48'd60_000_000);
      queue_cmd(CMD_FAILURE, 6'd21, TIME_MAX - 48'd60_000_000);
      queue_cmd(CMD_ALLOW,   6'd21, TIME_MAX - 48'd1);
      queue_cmd(CMD_ALLOW,   6'd21, TIME_MAX);
   endtask

   // cooldown 0 and threshold 1: alternate probe and failure until the tally pins
   task automatic saturate_tally();
      logic [5:0] e;
      e = 6'($urandom_range(0, ENTRIES - 1));
      sim_us += 48'($urandom_range(0, 100));
      queue_cmd(CMD_FAILURE, e, sim_us);
      repeat (260) begin
         sim_us += 48'($urandom_range(0, 100));
         queue_cmd(CMD_ALLOW, e, sim_us);
         queue_cmd(CMD_FAILURE, e, sim_us);
      end
   endtask

   // Mostly well-formed trip/probe sequences on a few busy entries, some noise
   task automatic random_cmds(int count);
      logic [5:0]  hot [4];
      logic [5:0]  e;
      logic [63:0] cool_us;
      int          done;
      int          pick;
      int          k;
      cool_us = 64'(cool_cfg) * 64'd1000000;
      foreach (hot[j]) hot[j] = 6'($urandom_range(0, ENTRIES - 1));
      done = 0;
      while (done < count) begin
         pick = $urandom_range(0, 99);
         e = hot[$urandom_range(0, 3)];
         if (pick < 30) begin
            k = int'(thr_cfg) + int'($urandom_range(0, 3));
            repeat (k) begin
               sim_us += 48'($urandom_range(0, 2000));
               queue_cmd(CMD_FAILURE, e, sim_us);
            end
            done += k;
         end else if (pick < 60) begin
            if ($urandom_range(0, 2) == 0) begin
               sim_us += cool_us[47:0] >> 1;
               queue_cmd(CMD_ALLOW, e, sim_us);
               done++;
            end
            sim_us += cool_us[47:0] + 48'($urandom_range(0, 50));
            queue_cmd(CMD_ALLOW, e, sim_us);
            queue_cmd(CMD_ALLOW, e, sim_us + 48'($urandom_range(0, 10)));
            sim_us += 48'($urandom_range(0, 1000));
            case ($urandom_range(0, 2))
               0: queue_cmd(CMD_SUCCESS, e, sim_us);
               1: queue_cmd(CMD_FAILURE, e, sim_us);
               default: queue_cmd(CMD_RELEASE, e, sim_us);
            endcase
            done += 3;
         end else if (pick < 75) begin
            k = $urandom_range(1, 4);
            repeat (k) begin
               sim_us += 48'($urandom_range(0, 2000));
               queue_cmd(cmd_type'($urandom_range(0, 3)), e, sim_us);
            end
            done += k;
         end else begin
            e = 6'($urandom_range(0, ENTRIES - 1));
            case ($urandom_range(0, 3))
               0: queue_cmd(cmd_type'($urandom_range(0, 3)), e, rand_time());
               1: queue_cmd(cmd_type'($urandom_range(0, 3)), e,
                            TIME_MAX - 48'($urandom_range(0, 1000)));
               default: begin
                  sim_us += 48'($urandom_range(0, 5000));
                  queue_cmd(cmd_type'($urandom_range(0, 3)), e, sim_us);
               end
            endcase
            done++;
         end
      end
   endtask

   initial begin
      foreach (mode_tab[i]) begin
         mode_tab[i] = MODE_CLOSED;
         tally_tab[i] = 8'd0;
         deadline_tab[i] = 48'd0;
         probe_tab[i] = 1'b0;
      end
      thr_cfg = THRESH_RST;
      cool_cfg = 16'd60;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_cmds();
      sim_us = 48'd200_000_000;
      random_cmds(250);
      drain();

      // threshold written as 0 clamps up to 1; no cooldown
      write_csr(CSR_FAIL_THRESHOLD, 16'hFFC0);
      write_csr(CSR_COOLDOWN_SECONDS, 16'h0000);
      saturate_tally();
      random_cmds(150);
      drain();

      // threshold written as 63 clamps down to 50; longest cooldown
      write_csr(CSR_FAIL_THRESHOLD, 16'h003F);
      write_csr(CSR_COOLDOWN_SECONDS, 16'hFFFF);
      random_cmds(250);
      drain();

      write_csr(CSR_FAIL_THRESHOLD, 16'h0002);
      write_csr(CSR_COOLDOWN_SECONDS, 16'h0001);
      random_cmds(250);
      drain();

      write_csr(CSR_FAIL_THRESHOLD, 16'h0032);
      write_csr(CSR_COOLDOWN_SECONDS, 16'h0003);
      random_cmds(200);
      drain();

      write_csr(CSR_FAIL_THRESHOLD, 16'hFFC1);
      write_csr(CSR_COOLDOWN_SECONDS, 16'h8000);
      random_cmds(150);
      drain();

      $display("Scored %0d breaker results over six register settings,", results_seen);
      $display("%0d grants, %0d results with a pinned failure count.", grants_seen,
               saturated_seen);
      if (mismatches == 0 && predicted_verdicts.size() == 0)
         $display("** per_entry_circuit_breaker: PASSED **");
      else
         $display("** per_entry_circuit_breaker: FAILED **");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d items queued and %0d results outstanding",
               pending_cmds.size(), predicted_verdicts.size());
      $display("** per_entry_circuit_breaker: FAILED **");
      $finish;
   end

endmodule
